// File: sv/ctts_pkg.sv
// Package for the cooperative task table scheduler: word types, task states and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ctts_pkg;
	localparam int NUM_TASKS = 16;
	localparam int NUM_SEMS = 8;
	localparam int TID_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam int SEM_W = 3;

	typedef enum logic [3:0] {
		K_ADD = 4'd0, K_EXIT = 4'd1, K_SLEEP = 4'd2, K_WAITZ = 4'd3, K_WAITNZ = 4'd4,
		K_SUSP = 4'd5, K_TICK = 4'd6, K_SCHED = 4'd7, K_SETSEM = 4'd8, K_COUNT = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		ST_NONE = 3'd0, ST_READY = 3'd1, ST_SUSP = 3'd2, ST_SLEEP = 3'd3,
		ST_WAITZ = 3'd4, ST_WAITNZ = 3'd5
	} tstate_t;

	typedef enum logic [1:0] {
		RS_OK = 2'd0, RS_FULL = 2'd1, RS_NULL = 2'd2, RS_DISPATCH = 2'd3
	} rstat_t;

	typedef enum logic [2:0] {
		S_IDLE, S_ONE, S_RD, S_SCAN, S_DONE
	} fsm_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  task_id;
		logic [7:0]  func_id;
		logic [31:0] wait_ticks;
		logic [2:0]  sem_index;
		logic [31:0] sem_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot;
		logic [7:0] dispatch_func;
		logic [4:0] free_slots;
		logic [4:0] func_count;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  st;
		logic [31:0] cnt;
		logic [7:0]  func;
		logic [2:0]  sem;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [TID_W-1:0] waddr;
		entry_t           wdata;
		logic [TID_W-1:0] raddr;
	} mem_req_t;
endpackage
`default_nettype wire

// File: sv/ctts_table.sv
// Task table memory: one entry per slot, synchronous read with the data registered in the cycle after the address.
// Depends on ctts_pkg. Entries are validated by a flip-flop per slot so reset reads as empty.
`timescale 1ns / 1ps
`default_nettype none
module ctts_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctts_pkg::mem_req_t req,
	output ctts_pkg::entry_t        rdata
);
	ctts_pkg::entry_t mem_q [ctts_pkg::NUM_TASKS];
	ctts_pkg::entry_t raw_q;
	logic [ctts_pkg::NUM_TASKS-1:0] vld_q;
	logic rv_q;

	always_ff @(posedge clk) begin
		if (req.we) mem_q[req.waddr] <= req.wdata;
		raw_q <= mem_q[req.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q <= 1'b0;
		end else begin
			if (req.we) vld_q[req.waddr] <= 1'b1;
			rv_q <= vld_q[req.raddr];
		end
	end

	assign rdata = rv_q ? raw_q : '0;
endmodule
`default_nettype wire

// File: sv/cooperative_task_table_scheduler_core.sv
// Top level of the cooperative task table scheduler: command sequencer around the task table.
// Depends on ctts_pkg and ctts_table.
//
//  channel   signals                 direction  notes
//  command   start, busy, cmd        in/out     word taken when start && !busy
//  result    res_valid, res          out        one-cycle strobe, no back pressure
//
// Add and set semaphore are handled in S_ONE; the next free slot is found from a per-slot
// occupancy vector. Exit, sleep, wait and suspend read, modify and write back the addressed
// slot through S_RD, S_SCAN and S_DONE. Tick, schedule and count walk the table one slot per
// cycle through the single table port; tick and schedule read-modify-write the slots they change.
// Reset empties the table at once. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module cooperative_task_table_scheduler_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire ctts_pkg::in_word_t   cmd,
	output logic                      busy,
	output logic                      res_valid,
	output ctts_pkg::out_word_t       res
);
	localparam int TW = ctts_pkg::TID_W;
	localparam int CW = ctts_pkg::CNT_W;

	ctts_pkg::fsm_t state_q, state_d;
	ctts_pkg::in_word_t cmd_q;
	logic [TW-1:0] idx_q, idx_d;
	logic [TW-1:0] ridx_s1;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] free_q, free_d;
	logic [ctts_pkg::NUM_TASKS-1:0] used_q, used_d;
	logic [ctts_pkg::NUM_SEMS-1:0] sem_q, sem_d;
	logic [TW-1:0] lastu_q, lastu_d;
	ctts_pkg::mem_req_t req;
	ctts_pkg::entry_t rd;
	ctts_pkg::entry_t nx;
	ctts_pkg::out_word_t res_d;
	logic rv_d;
	logic semnz;
	logic go;
	logic [TW-1:0] ff;
	logic ff_found;
	logic [TW-1:0] lu;

	ctts_table u_table (.clk(clk), .arst_n(arst_n), .req(req), .rdata(rd));

	always_comb begin
		ff = '0;
		ff_found = 1'b0;
		lu = '0;
		for (int i = ctts_pkg::NUM_TASKS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				ff = TW'(i);
				ff_found = 1'b1;
			end
		end
		for (int i = 0; i < ctts_pkg::NUM_TASKS; i++)
			if (used_q[i]) lu = TW'(i);
	end

	assign semnz = (32'(rd.sem) < 32'(ctts_pkg::NUM_SEMS)) ? sem_q[rd.sem] : 1'b0;
	assign busy = (state_q != ctts_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cnt_d = cnt_q;
		free_d = free_q;
		used_d = used_q;
		sem_d = sem_q;
		lastu_d = lastu_q;
		req = '0;
		req.raddr = idx_q;
		nx = rd;
		go = 1'b0;
		rv_d = 1'b0;
		res_d = '0;
		res_d.free_slots = free_q;
		res_d.last = 1'b1;
		unique case (state_q)
			ctts_pkg::S_IDLE: begin
				if (start) begin
					state_d = ctts_pkg::S_ONE;
					idx_d = '0;
					cnt_d = '0;
				end
			end
			ctts_pkg::S_ONE: begin
				state_d = ctts_pkg::S_IDLE;
				rv_d = 1'b1;
				priority case (cmd_q.kind)
					ctts_pkg::K_ADD: begin
						if (free_q == '0 || !ff_found) res_d.status = ctts_pkg::RS_FULL;
						else if (cmd_q.func_id == '0) res_d.status = ctts_pkg::RS_NULL;
						else begin
							req.we = 1'b1;
							req.waddr = ff;
							req.wdata = '{st: ctts_pkg::ST_READY, cnt: '0,
								func: cmd_q.func_id, sem: '0};
							used_d[ff] = 1'b1;
							free_d = free_q - 1'b1;
							if (lastu_q < ff) lastu_d = ff;
							res_d.slot = ff;
							res_d.free_slots = free_q - 1'b1;
						end
					end
					ctts_pkg::K_SETSEM: begin
						if (32'(cmd_q.sem_index) < 32'(ctts_pkg::NUM_SEMS))
							sem_d[cmd_q.sem_index] = (cmd_q.sem_value != '0);
					end
					ctts_pkg::K_EXIT, ctts_pkg::K_SLEEP, ctts_pkg::K_WAITZ,
					ctts_pkg::K_WAITNZ, ctts_pkg::K_SUSP, ctts_pkg::K_TICK,
					ctts_pkg::K_SCHED, ctts_pkg::K_COUNT: begin
						rv_d = 1'b0;
						state_d = ctts_pkg::S_RD;
						idx_d = (cmd_q.kind == ctts_pkg::K_TICK || cmd_q.kind == ctts_pkg::K_SCHED
							|| cmd_q.kind == ctts_pkg::K_COUNT) ? '0 : cmd_q.task_id;
						req.raddr = idx_d;
					end
					default: ;
				endcase
			end
			ctts_pkg::S_RD: begin
				state_d = ctts_pkg::S_SCAN;
				req.raddr = idx_q;
			end
			ctts_pkg::S_SCAN: begin
				req.raddr = idx_q + 1'b1;
				idx_d = idx_q + 1'b1;
				if (idx_q == TW'(ctts_pkg::NUM_TASKS - 1)) state_d = ctts_pkg::S_DONE;
				req.waddr = ridx_s1;
				unique case (cmd_q.kind)
					ctts_pkg::K_TICK: begin
						if (rd.st >= ctts_pkg::ST_SLEEP) begin
							req.we = 1'b1;
							if (rd.cnt != '0) nx.cnt = rd.cnt - 1'b1;
							else nx.st = ctts_pkg::ST_READY;
						end
					end
					ctts_pkg::K_COUNT: begin
						if (rd.st != ctts_pkg::ST_NONE && rd.func == cmd_q.func_id)
							cnt_d = cnt_q + 1'b1;
					end
					ctts_pkg::K_SCHED: begin
						if (idx_q <= lastu_q) begin
							go = (rd.st == ctts_pkg::ST_READY)
								|| (rd.st == ctts_pkg::ST_WAITZ && !semnz)
								|| (rd.st == ctts_pkg::ST_WAITNZ && semnz);
						end
						if (go) begin
							req.we = 1'b1;
							nx.st = ctts_pkg::ST_READY;
							rv_d = 1'b1;
							res_d.status = ctts_pkg::RS_DISPATCH;
							res_d.slot = idx_q;
							res_d.dispatch_func = rd.func;
							res_d.last = 1'b0;
						end
					end
					default: begin
						state_d = ctts_pkg::S_DONE;
						if (rd.st != ctts_pkg::ST_NONE) begin
							req.we = 1'b1;
							priority case (cmd_q.kind)
								ctts_pkg::K_EXIT: begin
									nx.st = ctts_pkg::ST_NONE;
									used_d[idx_q] = 1'b0;
									free_d = free_q + 1'b1;
								end
								ctts_pkg::K_SLEEP: begin
									nx.st = ctts_pkg::ST_SLEEP;
									nx.cnt = cmd_q.wait_ticks;
									nx.sem = '0;
								end
								ctts_pkg::K_WAITZ, ctts_pkg::K_WAITNZ: begin
									nx.st = (cmd_q.kind == ctts_pkg::K_WAITZ) ?
										ctts_pkg::ST_WAITZ : ctts_pkg::ST_WAITNZ;
									nx.cnt = cmd_q.wait_ticks;
									nx.sem = cmd_q.sem_index;
								end
								default: nx.st = ctts_pkg::ST_SUSP;
							endcase
						end
					end
				endcase
				req.wdata = nx;
			end
			ctts_pkg::S_DONE: begin
				state_d = ctts_pkg::S_IDLE;
				rv_d = 1'b1;
				if (cmd_q.kind == ctts_pkg::K_COUNT) res_d.func_count = cnt_q;
				if (cmd_q.kind == ctts_pkg::K_EXIT) lastu_d = lu;
			end
			default: state_d = ctts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctts_pkg::S_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			free_q <= CW'(ctts_pkg::NUM_TASKS);
			used_q <= '0;
			sem_q <= '0;
			lastu_q <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			cnt_q <= cnt_d;
			free_q <= free_d;
			used_q <= used_d;
			sem_q <= sem_d;
			lastu_q <= lastu_d;
			res_valid <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) cmd_q <= cmd;
		ridx_s1 <= req.raddr;
		res <= res_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> $past(state_q) == ctts_pkg::S_ONE
		|| $past(state_q) == ctts_pkg::S_DONE)
		else $error("final word outside a final state");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_q) + 32'($countones(used_q)) == ctts_pkg::NUM_TASKS)
		else $error("free count disagrees with occupancy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ctts_pkg::S_SCAN |-> ridx_s1 == idx_q)
		else $error("scan read address out of step");
endmodule
`default_nettype wire
